// ===== rtl/pess_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic event slot scheduler package
// Shared item types, the slot record and the opcode and result kind codes.
// ----------------------------------------------------------------------------
package pess_pkg;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_SERVICE  = 2'd2;

    localparam logic [2:0] KIND_REGISTERED = 3'd0;
    localparam logic [2:0] KIND_FULL       = 3'd1;
    localparam logic [2:0] KIND_TICKED     = 3'd2;
    localparam logic [2:0] KIND_FIRED      = 3'd3;
    localparam logic [2:0] KIND_IDLE       = 3'd4;

    // At most this many slots are reported by one service item.
    localparam logic [3:0] MAX_FIRE = 4'd8;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] period_ticks;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] slot_index;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic        used;
        logic        pending;
        logic [15:0] reload;
        logic [15:0] countdown;
    } slot_rec_t;

endpackage

// ===== rtl/pess_cell.sv =====
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot record and takes its neighbor's record when the ring shifts.
// ----------------------------------------------------------------------------
module pess_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  pess_pkg::slot_rec_t d,
    output pess_pkg::slot_rec_t q
);

    pess_pkg::slot_rec_t rec_reg;
    pess_pkg::slot_rec_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (shift)
        begin
            rec_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign q = rec_reg;

endmodule

// ===== rtl/pess_ring.sv =====
// ----------------------------------------------------------------------------
// Slot ring
// A chain of slot cells closed into a ring through the head update logic.
// ----------------------------------------------------------------------------
module pess_ring #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  pess_pkg::slot_rec_t head_in,
    output pess_pkg::slot_rec_t head_out
);

    pess_pkg::slot_rec_t rec_q [SLOTS];

    genvar i;
    generate
        for (i = 0; i < SLOTS; i++)
        begin : g_cell
            pess_pkg::slot_rec_t cell_d;
            if (i == SLOTS - 1)
            begin : g_tail
                assign cell_d = head_in;
            end
            else
            begin : g_body
                assign cell_d = rec_q[i + 1];
            end
            pess_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_d),
                .q     (rec_q[i])
            );
        end
    endgenerate

    assign head_out = rec_q[0];

endmodule

// ===== rtl/periodic_event_slot_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Periodic event slot scheduler
// Rotating ring of slot cells, swept once per register, tick or service item.
// ----------------------------------------------------------------------------
// The slot records circulate through a ring of SLOTS cells. Every register,
// tick or service item is handled by one full rotation in which each slot
// passes the head logic once, in index order; an unused opcode is dropped.
// A swept item passes acceptance, SLOTS rotation steps and the final result;
// a step that pushes out an earlier fire, or the final result, waits while the
// output register holds a stalled result. Only one item is in work at a time;
// the input is stalled until the final result has been loaded into the output
// register, and a new item can be accepted while that result waits to be taken.
module periodic_event_slot_scheduler_top #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pess_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output pess_pkg::out_item_t out_item
);

    localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [15:0]         period_reg, period_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                found_reg, found_next;
    logic [2:0]          found_idx_reg, found_idx_next;
    logic                held_valid_reg, held_valid_next;
    logic [2:0]          held_idx_reg, held_idx_next;
    logic [3:0]          fired_reg, fired_next;
    logic                out_valid_reg, out_valid_next;
    pess_pkg::out_item_t out_item_reg, out_item_next;

    pess_pkg::slot_rec_t head;
    pess_pkg::slot_rec_t head_new;
    logic                step;
    logic                out_free;
    logic                fire;
    logic [6:0]          idx_wide;
    logic [2:0]          idx3;

    pess_ring #(
        .SLOTS (SLOTS)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (step),
        .head_in  (head_new),
        .head_out (head)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign idx_wide = 7'(cnt_reg);
    assign idx3     = idx_wide[2:0];
    assign fire     = (op_reg == pess_pkg::OP_SERVICE) && head.used && head.pending
                      && (fired_reg < pess_pkg::MAX_FIRE);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        period_next     = period_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        fired_next      = fired_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = out_valid_reg && out_stall;
        head_new        = head;
        step            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_item.opcode;
                    period_next     = in_item.period_ticks;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    held_valid_next = 1'b0;
                    fired_next      = '0;
                    if ((in_item.opcode == pess_pkg::OP_REGISTER)
                        || (in_item.opcode == pess_pkg::OP_TICK)
                        || (in_item.opcode == pess_pkg::OP_SERVICE))
                    begin
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                // A new fire pushes out the one held before it, which needs room.
                if (!(fire && held_valid_reg) || out_free)
                begin
                    step = 1'b1;
                    case (op_reg)
                        pess_pkg::OP_REGISTER:
                        begin
                            if (!head.used && !found_reg)
                            begin
                                head_new.used      = 1'b1;
                                head_new.pending   = 1'b0;
                                head_new.reload    = period_reg;
                                head_new.countdown = '0;
                                found_next         = 1'b1;
                                found_idx_next     = idx3;
                            end
                        end
                        pess_pkg::OP_TICK:
                        begin
                            if (head.used)
                            begin
                                if (head.countdown == 16'd0)
                                begin
                                    head_new.countdown = head.reload;
                                    head_new.pending   = 1'b1;
                                end
                                else
                                begin
                                    head_new.countdown = head.countdown - 16'd1;
                                end
                            end
                        end
                        default:
                        begin
                            if (fire)
                            begin
                                head_new.pending = 1'b0;
                                if (held_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_item_next  = '{kind: pess_pkg::KIND_FIRED,
                                                      slot_index: held_idx_reg,
                                                      last: 1'b0};
                                end
                                held_valid_next = 1'b1;
                                held_idx_next   = idx3;
                                fired_next      = fired_reg + 4'd1;
                            end
                        end
                    endcase
                    if (cnt_reg == LAST_SLOT)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (op_reg)
                        pess_pkg::OP_REGISTER:
                        begin
                            if (found_reg)
                            begin
                                out_item_next = '{kind: pess_pkg::KIND_REGISTERED,
                                                  slot_index: found_idx_reg, last: 1'b1};
                            end
                            else
                            begin
                                out_item_next = '{kind: pess_pkg::KIND_FULL,
                                                  slot_index: 3'd0, last: 1'b1};
                            end
                        end
                        pess_pkg::OP_TICK:
                        begin
                            out_item_next = '{kind: pess_pkg::KIND_TICKED,
                                              slot_index: 3'd0, last: 1'b1};
                        end
                        default:
                        begin
                            if (held_valid_reg)
                            begin
                                out_item_next = '{kind: pess_pkg::KIND_FIRED,
                                                  slot_index: held_idx_reg, last: 1'b1};
                            end
                            else
                            begin
                                out_item_next = '{kind: pess_pkg::KIND_IDLE,
                                                  slot_index: 3'd0, last: 1'b1};
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            fired_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            held_valid_reg <= held_valid_next;
            fired_reg      <= fired_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        period_reg    <= period_next;
        found_idx_reg <= found_idx_next;
        held_idx_reg  <= held_idx_next;
        out_item_reg  <= out_item_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== verif/pess_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic event slot scheduler checker
// Watches both channels of the scheduler, keeps its own copy of the slot
// table, predicts the results of every accepted item and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pess_checker #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  pess_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_stall,
    input  pess_pkg::out_item_t out_item,
    output int                  mismatches,
    output int                  awaited,
    output int                  items_seen,
    output int                  results_seen,
    output int                  fires_seen,
    output int                  full_seen
);

    bit          slot_taken [SLOTS];
    logic [15:0] slot_reload[SLOTS];
    logic [15:0] slot_count [SLOTS];
    bit          slot_armed [SLOTS];

    pess_pkg::out_item_t scheduled_results[$];

    int fail_count;
    int item_count;
    int result_count;
    int fire_count;
    int full_count;

    task automatic push_result(logic [2:0] kind, int idx, logic last);
        pess_pkg::out_item_t r;
        r.kind       = kind;
        r.slot_index = idx[2:0];
        r.last       = last;
        scheduled_results.push_back(r);
    endtask

    task automatic model_slot_table(pess_pkg::in_item_t it);
        int  i;
        int  n;
        bit  placed;
        int  fired_idx[8];
        placed = 1'b0;
        n = 0;
        case (it.opcode)
            pess_pkg::OP_REGISTER:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!placed && !slot_taken[i])
                    begin
                        slot_taken[i]  = 1'b1;
                        slot_reload[i] = it.period_ticks;
                        slot_count[i]  = 16'd0;
                        slot_armed[i]  = 1'b0;
                        placed = 1'b1;
                        push_result(pess_pkg::KIND_REGISTERED, i, 1'b1);
                    end
                end
                if (!placed)
                    push_result(pess_pkg::KIND_FULL, 0, 1'b1);
            end
            pess_pkg::OP_TICK:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_taken[i])
                    begin
                        if (slot_count[i] == 16'd0)
                        begin
                            slot_count[i] = slot_reload[i];
                            slot_armed[i] = 1'b1;
                        end
                        else
                            slot_count[i] = slot_count[i] - 16'd1;
                    end
                end
                push_result(pess_pkg::KIND_TICKED, 0, 1'b1);
            end
            pess_pkg::OP_SERVICE:
            begin
                // Only the first MAX_FIRE pending slots are reported; the rest
                // keep their marks for the next service item.
                for (i = 0; i < SLOTS; i++)
                begin
                    if (n < int'(pess_pkg::MAX_FIRE) && slot_taken[i] && slot_armed[i])
                    begin
                        slot_armed[i] = 1'b0;
                        fired_idx[n] = i;
                        n++;
                    end
                end
                if (n == 0)
                    push_result(pess_pkg::KIND_IDLE, 0, 1'b1);
                for (i = 0; i < n; i++)
                    push_result(pess_pkg::KIND_FIRED, fired_idx[i], i == n - 1);
            end
            default:
            begin
                // The unused opcode leaves the table alone and gives no result.
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < 40)
            $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pess_pkg::out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_taken[i]  = 1'b0;
                slot_reload[i] = 16'd0;
                slot_count[i]  = 16'd0;
                slot_armed[i]  = 1'b0;
            end
            scheduled_results.delete();
            fail_count   = 0;
            item_count   = 0;
            result_count = 0;
            fire_count   = 0;
            full_count   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                model_slot_table(in_item);
                item_count++;
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (out_item.kind == pess_pkg::KIND_FIRED)
                    fire_count++;
                if (out_item.kind == pess_pkg::KIND_FULL)
                    full_count++;
                if (scheduled_results.size() == 0)
                    report_mismatch("result with nothing awaited, kind",
                                    int'(out_item.kind), -1);
                else
                begin
                    want = scheduled_results.pop_front();
                    if (out_item.kind != want.kind)
                        report_mismatch("kind", int'(out_item.kind), int'(want.kind));
                    if (out_item.slot_index != want.slot_index)
                        report_mismatch("slot_index", int'(out_item.slot_index),
                                        int'(want.slot_index));
                    if (out_item.last != want.last)
                        report_mismatch("last", int'(out_item.last), int'(want.last));
                end
            end
        end
        mismatches   <= fail_count;
        awaited      <= scheduled_results.size();
        items_seen   <= item_count;
        results_seen <= result_count;
        fires_seen   <= fire_count;
        full_seen    <= full_count;
    end

endmodule

// ===== verif/periodic_event_slot_scheduler_top_tb.sv =====
// ----------------------------------------------------------------------------
// Periodic event slot scheduler testbench
// Drives directed and random register, tick, service and unused-opcode items
// with random idling on both channels; verdict from the checker's count.
// ----------------------------------------------------------------------------
module periodic_event_slot_scheduler_top_tb;

    localparam int         SLOTS       = 8;
    localparam int         RANDOM_ITEMS = 480;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic                rst_n     = 1'b0;
    logic                clk;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    pess_pkg::in_item_t  in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pess_pkg::out_item_t out_item;

    bit idling = 1'b1;
    int stall_left = 0;
    int cycles = 0;

    int mismatches;
    int awaited;
    int items_seen;
    int results_seen;
    int fires_seen;
    int full_seen;

    periodic_event_slot_scheduler_top #(
        .SLOTS(SLOTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    pess_checker #(
        .SLOTS(SLOTS)
    ) slot_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .mismatches  (mismatches),
        .awaited     (awaited),
        .items_seen  (items_seen),
        .results_seen(results_seen),
        .fires_seen  (fires_seen),
        .full_seen   (full_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Random receiver stall bursts and free-running stretches while idling is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (!idling)
            out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(1, 13) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 30);
        end
    end

    task automatic send_item(logic [1:0] op, logic [15:0] period);
        pess_pkg::in_item_t it;
        it.opcode       = op;
        it.period_ticks = period;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Lowers valid and waits until the checker awaits no more results.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          pick;
        logic [15:0] period;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then the unused opcode.
        send_item(pess_pkg::OP_SERVICE, 16'h0000);
        send_item(pess_pkg::OP_TICK, 16'hFFFF);
        send_item(OP_UNUSED, 16'hFFFF);
        // Shortest, longest and a short interval; the first tick fires all three.
        send_item(pess_pkg::OP_REGISTER, 16'h0000);
        send_item(pess_pkg::OP_REGISTER, 16'hFFFF);
        send_item(pess_pkg::OP_REGISTER, 16'h0001);
        send_item(pess_pkg::OP_TICK, 16'h5555);
        send_item(pess_pkg::OP_TICK, 16'hAAAA);
        repeat (5)
            send_item(pess_pkg::OP_REGISTER, 16'($urandom_range(0, 6)));
        send_item(pess_pkg::OP_REGISTER, 16'hFFFF);
        // Every slot is pending now, so the service reports all eight.
        send_item(pess_pkg::OP_TICK, 16'h0000);
        send_item(pess_pkg::OP_SERVICE, 16'hFFFF);
        send_item(pess_pkg::OP_SERVICE, 16'h0000);
        send_item(pess_pkg::OP_TICK, 16'h1234);
        send_item(pess_pkg::OP_TICK, 16'hEDCB);
        send_item(pess_pkg::OP_SERVICE, 16'h8001);
        send_item(OP_UNUSED, 16'h0000);

        while (sent < RANDOM_ITEMS)
        begin
            if (sent == RANDOM_ITEMS / 2)
                wait_for_results();
            if (sent == RANDOM_ITEMS - 60)
                idling <= 1'b0;
            pick   = $urandom_range(0, 99);
            period = 16'($urandom());
            if (pick < 8)
                send_item(pess_pkg::OP_REGISTER, period);
            else if (pick < 58)
                send_item(pess_pkg::OP_TICK, period);
            else if (pick < 95)
                send_item(pess_pkg::OP_SERVICE, period);
            else
                send_item(OP_UNUSED, period);
            if (pick < 95)
                sent++;
        end

        wait_for_results();
        repeat (40) @(posedge clk);

        $display("Run covered %0d accepted items and %0d checked results,", items_seen,
                 results_seen);
        $display("including %0d slot fires and %0d table-full replies.", fires_seen, full_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
